@@ rtl/core/crc_pkg.sv @@
// shared types, constants and step functions for the circle-rectangle pushout pipeline
package crc_pkg;

	localparam int SQ_STEPS  = 30;
	localparam int DIV_STEPS = 22;

	typedef enum logic [1:0] {
		HIT_NONE   = 2'd0,
		HIT_CORNER = 2'd1,
		HIT_SIDE_X = 2'd2,
		HIT_SIDE_Y = 2'd3
	} hit_kind_t;

	typedef enum logic [1:0] {
		REG_LEFT   = 2'd0,
		REG_TOP    = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [23:0] center_x;
		logic signed [23:0] center_y;
		logic [21:0]        radius;
	} in_t;

	typedef struct packed {
		logic signed [23:0] new_x;
		logic signed [23:0] new_y;
		logic [1:0]         hit_kind;
		logic [1:0]         hit_index;
	} out_t;

	typedef struct packed {
		logic signed [25:0] nx;
		logic signed [25:0] ny;
		logic signed [25:0] kx;
		logic signed [25:0] ky;
		logic               sx;
		logic               sy;
		logic               push;
		hit_kind_t          kind;
		logic [1:0]         idx;
	} ctx_t;

	typedef struct packed {
		ctx_t        ctx;
		logic [44:0] s;
		logic [21:0] mx;
		logic [21:0] my;
		logic [21:0] r;
	} fr_t;

	typedef struct packed {
		ctx_t        ctx;
		logic [60:0] rem;
		logic [29:0] root;
		logic [21:0] mx;
		logic [21:0] my;
		logic [21:0] r;
	} sq_t;

	typedef struct packed {
		ctx_t        ctx;
		logic [29:0] d2;
		logic [29:0] rx;
		logic [29:0] ry;
		logic [21:0] lx;
		logic [21:0] ly;
		logic [21:0] qx;
		logic [21:0] qy;
	} dv_t;

	function automatic sq_t sq_step(input sq_t a, input int b);
		sq_t         o;
		logic [60:0] cand;
		o = a;
		cand = (61'(a.root) << (b + 1)) | (61'(1) << (2 * b));
		if (a.rem >= cand) begin
			o.rem  = a.rem - cand;
			o.root = a.root | (30'(1) << b);
		end
		return o;
	endfunction

	function automatic logic [30:0] div_bit(input logic [29:0] rem, input logic [29:0] d2,
		input logic nb);
		logic [30:0] t;
		t = {rem, nb};
		if (t >= {1'b0, d2}) begin
			return {1'b1, 30'(t - {1'b0, d2})};
		end
		return {1'b0, t[29:0]};
	endfunction

	function automatic dv_t dv_step(input dv_t a, input int i);
		dv_t         o;
		logic [30:0] bx;
		logic [30:0] by;
		o = a;
		bx = div_bit(a.rx, a.d2, a.lx[i]);
		by = div_bit(a.ry, a.d2, a.ly[i]);
		o.rx = bx[29:0];
		o.ry = by[29:0];
		o.qx[i] = bx[30];
		o.qy[i] = by[30];
		return o;
	endfunction

	function automatic logic [23:0] sat24(input logic signed [25:0] v);
		if (v[25:23] == 3'b000 || v[25:23] == 3'b111) begin
			return v[23:0];
		end
		return v[25] ? 24'h800000 : 24'h7fffff;
	endfunction

endpackage

@@ rtl/core/crc_front.sv @@
// front stages: corner and side distance tests, hit selection
module crc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld,
	input  crc_pkg::in_t           din,
	input  logic signed [23:0]     left,
	input  logic signed [23:0]     top,
	input  logic [22:0]            width,
	input  logic [22:0]            height,
	output logic                   vld_s3,
	output crc_pkg::fr_t           fr_s3
);

	logic               vld_s1;
	crc_pkg::in_t       in_s1;
	logic               vld_s2;
	crc_pkg::in_t       in_s2;
	logic signed [25:0] d_s2 [4];
	logic [21:0]        mag_s2 [4];
	logic [43:0]        sq_s2 [4];
	logic [43:0]        rr_s2;

	logic signed [25:0] left26, top26, right26, bottom26;
	logic signed [25:0] d [4];
	logic [21:0]        mag [4];
	logic [43:0]        sq [4];
	crc_pkg::fr_t       fr;

	assign left26   = {{2{left[23]}}, left};
	assign top26    = {{2{top[23]}}, top};
	assign right26  = left26 + {3'b0, width};
	assign bottom26 = top26 + {3'b0, height};

	always_comb begin
		logic signed [25:0] cx26, cy26;
		logic [25:0]        a;
		cx26 = {{2{in_s1.center_x[23]}}, in_s1.center_x};
		cy26 = {{2{in_s1.center_y[23]}}, in_s1.center_y};
		d[0] = cx26 - left26;
		d[1] = cx26 - right26;
		d[2] = cy26 - top26;
		d[3] = cy26 - bottom26;
		for (int j = 0; j < 4; j++) begin
			a = d[j][25] ? 26'(-d[j]) : d[j];
			mag[j] = (|a[25:22]) ? 22'h3fffff : a[21:0];
			sq[j] = 44'(mag[j]) * 44'(mag[j]);
		end
	end

	always_comb begin
		logic               in_x, in_y;
		logic [44:0]        s;
		logic [2:0]         sel;
		logic [1:0]         xi, yi;
		logic signed [25:0] r26;
		logic signed [25:0] cx26, cy26;
		in_x = !d_s2[0][25] && d_s2[0] != '0 && d_s2[1][25];
		in_y = !d_s2[2][25] && d_s2[2] != '0 && d_s2[3][25];
		r26  = {4'b0, in_s2.radius};
		cx26 = {{2{in_s2.center_x[23]}}, in_s2.center_x};
		cy26 = {{2{in_s2.center_y[23]}}, in_s2.center_y};
		sel = 3'd4;
		for (int i = 3; i >= 0; i--) begin
			xi = (i == 0 || i == 1) ? 2'd0 : 2'd1;
			yi = (i == 0 || i == 3) ? 2'd2 : 2'd3;
			s = {1'b0, sq_s2[xi]} + {1'b0, sq_s2[yi]};
			if (!in_x && !in_y && s < {1'b0, rr_s2}) begin
				sel = 3'(i);
			end
		end
		fr = '0;
		fr.r = in_s2.radius;
		fr.ctx.nx = cx26;
		fr.ctx.ny = cy26;
		fr.ctx.kind = crc_pkg::HIT_NONE;
		if (!sel[2]) begin
			xi = (sel[1:0] == 2'd0 || sel[1:0] == 2'd1) ? 2'd0 : 2'd1;
			yi = (sel[1:0] == 2'd0 || sel[1:0] == 2'd3) ? 2'd2 : 2'd3;
			fr.s = {1'b0, sq_s2[xi]} + {1'b0, sq_s2[yi]};
			fr.mx = mag_s2[xi];
			fr.my = mag_s2[yi];
			fr.ctx.kind = crc_pkg::HIT_CORNER;
			fr.ctx.idx = sel[1:0];
			fr.ctx.kx = (xi == 2'd0) ? left26 : right26;
			fr.ctx.ky = (yi == 2'd2) ? top26 : bottom26;
			fr.ctx.sx = d_s2[xi][25];
			fr.ctx.sy = d_s2[yi][25];
			fr.ctx.push = fr.s != '0;
		end
		if (fr.ctx.kind == crc_pkg::HIT_NONE && in_y) begin
			if (mag_s2[0] < in_s2.radius) begin
				fr.ctx.kind = crc_pkg::HIT_SIDE_X;
				fr.ctx.idx = 2'd0;
				if (d_s2[0] != '0) begin
					fr.ctx.nx = d_s2[0][25] ? left26 - r26 : left26 + r26;
				end
			end else if (mag_s2[1] < in_s2.radius) begin
				fr.ctx.kind = crc_pkg::HIT_SIDE_X;
				fr.ctx.idx = 2'd1;
				if (d_s2[1] != '0) begin
					fr.ctx.nx = d_s2[1][25] ? right26 - r26 : right26 + r26;
				end
			end
		end
		if (fr.ctx.kind == crc_pkg::HIT_NONE && in_x) begin
			if (mag_s2[3] < in_s2.radius) begin
				fr.ctx.kind = crc_pkg::HIT_SIDE_Y;
				fr.ctx.idx = 2'd2;
				if (d_s2[3] != '0) begin
					fr.ctx.ny = d_s2[3][25] ? bottom26 - r26 : bottom26 + r26;
				end
			end else if (mag_s2[2] < in_s2.radius) begin
				fr.ctx.kind = crc_pkg::HIT_SIDE_Y;
				fr.ctx.idx = 2'd3;
				if (d_s2[2] != '0) begin
					fr.ctx.ny = d_s2[2][25] ? top26 - r26 : top26 + r26;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= din;
			in_s2 <= in_s1;
			d_s2 <= d;
			mag_s2 <= mag;
			sq_s2 <= sq;
			rr_s2 <= 44'(in_s1.radius) * 44'(in_s1.radius);
			fr_s3 <= fr;
		end
	end

endmodule

@@ rtl/core/crc_sqrt.sv @@
// pipelined square root of the corner distance, one root bit per stage
module crc_sqrt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld,
	input  crc_pkg::fr_t fr,
	output logic         vld_o,
	output crc_pkg::sq_t sq_o
);

	crc_pkg::sq_t              entry;
	crc_pkg::sq_t              st_s [1:crc_pkg::SQ_STEPS];
	logic [crc_pkg::SQ_STEPS:1] vld_s;

	always_comb begin
		entry = '0;
		entry.ctx = fr.ctx;
		entry.rem = {fr.s, 16'b0};
		entry.mx = fr.mx;
		entry.my = fr.my;
		entry.r = fr.r;
	end

	for (genvar k = 1; k <= crc_pkg::SQ_STEPS; k++) begin : g_st
		crc_pkg::sq_t src;
		logic         src_vld;
		if (k == 1) begin : g_first
			assign src = entry;
			assign src_vld = vld;
		end else begin : g_next
			assign src = st_s[k-1];
			assign src_vld = vld_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= src_vld;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= crc_pkg::sq_step(src, crc_pkg::SQ_STEPS - k);
			end
		end
	end

	assign vld_o = vld_s[crc_pkg::SQ_STEPS];
	assign sq_o = st_s[crc_pkg::SQ_STEPS];

endmodule

@@ rtl/core/crc_div.sv @@
// offset scaling: products, rounding bias and pipelined restoring division
module crc_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld,
	input  crc_pkg::sq_t sq,
	output logic         vld_o,
	output crc_pkg::dv_t dv_o
);

	logic                        vld_m1, vld_m2;
	logic [43:0]                 px_m1, py_m1;
	logic [29:0]                 d2_m1;
	crc_pkg::ctx_t               ctx_m1;
	crc_pkg::dv_t                init_m2;
	crc_pkg::dv_t                init;
	crc_pkg::dv_t                st_s [1:crc_pkg::DIV_STEPS];
	logic [crc_pkg::DIV_STEPS:1] vld_s;

	always_comb begin
		logic [52:0] nx, ny;
		nx = {1'b0, px_m1, 8'b0} + {24'b0, d2_m1[29:1]};
		ny = {1'b0, py_m1, 8'b0} + {24'b0, d2_m1[29:1]};
		init = '0;
		init.ctx = ctx_m1;
		init.d2 = d2_m1;
		init.rx = nx[51:22];
		init.ry = ny[51:22];
		init.lx = nx[21:0];
		init.ly = ny[21:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m1 <= 1'b0;
			vld_m2 <= 1'b0;
		end else if (en) begin
			vld_m1 <= vld;
			vld_m2 <= vld_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_m1 <= 44'(sq.mx) * 44'(sq.r);
			py_m1 <= 44'(sq.my) * 44'(sq.r);
			d2_m1 <= sq.root;
			ctx_m1 <= sq.ctx;
			init_m2 <= init;
		end
	end

	for (genvar k = 1; k <= crc_pkg::DIV_STEPS; k++) begin : g_st
		crc_pkg::dv_t src;
		logic         src_vld;
		if (k == 1) begin : g_first
			assign src = init_m2;
			assign src_vld = vld_m2;
		end else begin : g_next
			assign src = st_s[k-1];
			assign src_vld = vld_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= src_vld;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= crc_pkg::dv_step(src, crc_pkg::DIV_STEPS - k);
			end
		end
	end

	assign vld_o = vld_s[crc_pkg::DIV_STEPS];
	assign dv_o = st_s[crc_pkg::DIV_STEPS];

endmodule

@@ rtl/core/circle_rect_collision_pushout_unit.sv @@
// top level: register port, pipeline chain and saturating output register
// pipeline: 3 test stages, 30 square-root stages, 2 product stages, 22 divider stages
//   and the output register
// throughput: one word per cycle; the whole pipeline advances together and holds when
//   the output word is not taken
// reset: asynchronous, clears all valid bits and the rectangle registers to zero
module circle_rect_collision_pushout_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         in_valid,
	output logic         in_ready,
	input  crc_pkg::in_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output crc_pkg::out_t out_data
);

	logic signed [23:0] left_q, top_q;
	logic [22:0]        width_q, height_q;
	logic               en;
	logic               fr_vld, sq_vld, dv_vld;
	crc_pkg::fr_t       fr;
	crc_pkg::sq_t       sq;
	crc_pkg::dv_t       dv;
	logic               out_valid_q;
	crc_pkg::out_t      out_q;
	crc_pkg::out_t      res;
	crc_pkg::reg_idx_t  ridx;

	assign pready = 1'b1;
	assign ridx = crc_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			top_q <= '0;
			width_q <= '0;
			height_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				crc_pkg::REG_LEFT:   left_q <= pwdata[23:0];
				crc_pkg::REG_TOP:    top_q <= pwdata[23:0];
				crc_pkg::REG_WIDTH:  width_q <= pwdata[22:0];
				crc_pkg::REG_HEIGHT: height_q <= pwdata[22:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			crc_pkg::REG_LEFT:   prdata = {{8{left_q[23]}}, left_q};
			crc_pkg::REG_TOP:    prdata = {{8{top_q[23]}}, top_q};
			crc_pkg::REG_WIDTH:  prdata = {9'b0, width_q};
			crc_pkg::REG_HEIGHT: prdata = {9'b0, height_q};
			default:             prdata = '0;
		endcase
	end

	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	crc_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(in_valid && in_ready), .din(in_data),
		.left(left_q), .top(top_q), .width(width_q), .height(height_q),
		.vld_s3(fr_vld), .fr_s3(fr)
	);

	crc_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(fr_vld), .fr(fr),
		.vld_o(sq_vld), .sq_o(sq)
	);

	crc_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(sq_vld), .sq(sq),
		.vld_o(dv_vld), .dv_o(dv)
	);

	always_comb begin
		logic signed [25:0] nx, ny, qx26, qy26;
		qx26 = {4'b0, dv.qx};
		qy26 = {4'b0, dv.qy};
		nx = dv.ctx.nx;
		ny = dv.ctx.ny;
		if (dv.ctx.push) begin
			nx = dv.ctx.sx ? dv.ctx.kx - qx26 : dv.ctx.kx + qx26;
			ny = dv.ctx.sy ? dv.ctx.ky - qy26 : dv.ctx.ky + qy26;
		end
		res.new_x = crc_pkg::sat24(nx);
		res.new_y = crc_pkg::sat24(ny);
		res.hit_kind = dv.ctx.kind;
		res.hit_index = dv.ctx.idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_none_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit_kind == crc_pkg::HIT_NONE |-> out_data.hit_index == 2'd0)
		else $error("no-hit word with nonzero index");
	a_side_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit_kind == crc_pkg::HIT_SIDE_X |-> !out_data.hit_index[1])
		else $error("left/right push with bottom/top index");
	a_side_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit_kind == crc_pkg::HIT_SIDE_Y |-> out_data.hit_index[1])
		else $error("bottom/top push with left/right index");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a held output word");

endmodule
